// ===== hdl/sfla_pkg.sv =====
// Package for the segregated free-list allocator: field widths, operation and
// status codes, the classified request item and the back-end sequencer states.
// No dependencies.
`default_nettype none

package sfla_pkg;

	// Field widths fixed by the request and result formats.
	localparam int ADDR_W   = 16;
	localparam int SIZE_W   = 12;
	localparam int STATUS_W = 2;
	localparam int BATCH_W  = 7;
	localparam int CLS_W    = 6;

	// Refill batch limits and reset value.
	localparam logic [BATCH_W-1:0] BATCH_MAX   = 7'd64;
	localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd20;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BIG       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

	// Classified request as it travels from the front end to the back end.
	typedef struct packed {
		logic              operation;
		logic              too_big;
		logic [CLS_W-1:0]  cls;
		logic [ADDR_W-1:0] address;
	} sfla_item_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_POPA,
		BK_POPB,
		BK_CARVE,
		BK_FRAGA,
		BK_FRAGB,
		BK_RES
	} sfla_state_t;

endpackage

`default_nettype wire

// ===== hdl/sfla_req_if.sv =====
// Request channel of the allocator: valid/ready handshake plus the request fields.
// Depends on sfla_pkg.
`default_nettype none

interface sfla_req_if;
	import sfla_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [SIZE_W-1:0] size_bytes;
	logic [ADDR_W-1:0] address;

	modport source(output valid, output operation, output size_bytes, output address,
		input ready);
	modport sink(input valid, input operation, input size_bytes, input address,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/sfla_res_if.sv =====
// Result channel of the allocator: valid/ready handshake plus the result fields.
// Depends on sfla_pkg.
`default_nettype none

interface sfla_res_if;
	import sfla_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   address_res;
	logic [STATUS_W-1:0] status;

	modport source(output valid, output address_res, output status, input ready);
	modport sink(input valid, input address_res, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfla_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; a read of the address being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// ===== hdl/sfla_front.sv =====
// Front end: takes request items and classifies them by size class.
// Depends on sfla_pkg and sfla_req_if.
`default_nettype none

module sfla_front #(
	parameter int ALIGN       = 8,
	parameter int NUM_CLASSES = 16,
	parameter int MAX_BLOCK   = 128
) (
	sfla_req_if.sink             req,
	output sfla_pkg::sfla_item_t item,
	output logic                 item_valid,
	input  logic                 item_ready
);
	import sfla_pkg::*;

	// Division by ALIGN as a multiply by a rounded-up reciprocal, exact for EXT_W-bit values.
	localparam int EXT_W = SIZE_W + 1;
	localparam int L     = $clog2(ALIGN);
	localparam int SH    = EXT_W + L;
	localparam int RW    = EXT_W + 2;
	localparam int PW    = EXT_W + RW;
	localparam int unsigned RECIP = ((32'd1 << SH) + ALIGN - 1) / ALIGN;

	logic [EXT_W-1:0] rounded;
	logic [PW-1:0]    prod;
	logic [EXT_W-1:0] quo;
	logic             size_zero;
	logic             too_big;

	// Round the size up to whole ALIGN units and find the class.
	always_comb begin
		rounded   = EXT_W'(req.size_bytes) + EXT_W'(ALIGN - 1);
		prod      = PW'(rounded) * PW'(RECIP);
		quo       = EXT_W'(prod >> SH);
		size_zero = (req.size_bytes == '0);
		too_big   = (EXT_W'(req.size_bytes) > EXT_W'(MAX_BLOCK))
			|| (!size_zero && (quo > EXT_W'(NUM_CLASSES)));
	end

	always_comb begin
		item.operation = req.operation;
		item.too_big   = too_big;
		item.cls       = size_zero ? '0 : CLS_W'(quo - EXT_W'(1));
		item.address   = req.address;
	end

	assign item_valid = req.valid;
	assign req.ready  = item_ready;
endmodule

`default_nettype wire

// ===== hdl/sfla_queue.sv =====
// Two-entry queue that decouples the classifying front end from the back end.
// Depends on sfla_pkg.
`default_nettype none

module sfla_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  sfla_pkg::sfla_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop,
	output sfla_pkg::sfla_item_t pop_item
);
	import sfla_pkg::*;

	sfla_item_t entries_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entries_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wptr_q] <= push_item;
		end
	end
endmodule

`default_nettype wire

// ===== hdl/sfla_back.sv =====
// Back end: sequencer that owns the list heads, the link memory and the bump pointer,
// and carries out allocate and free items. Depends on sfla_pkg, sfla_res_if, sfla_ram.
`default_nettype none

module sfla_back #(
	parameter int ALIGN       = 8,
	parameter int NUM_CLASSES = 16,
	parameter int POOL_BYTES  = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  sfla_pkg::sfla_item_t          q_item,
	input  logic                          cfg_we,
	input  logic [sfla_pkg::BATCH_W-1:0]  cfg_wdata,
	sfla_res_if.source                    res
);
	import sfla_pkg::*;

	localparam int LINK_DEPTH = POOL_BYTES / ALIGN;
	localparam int LAW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
	localparam int SW  = $clog2(LINK_DEPTH + 1);
	localparam int CAW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int BW  = ADDR_W + 1;
	localparam int BSW = 13;
	// Division by ALIGN as a multiply by a rounded-up reciprocal, exact for BW-bit values.
	localparam int L   = $clog2(ALIGN);
	localparam int SH  = BW + L;
	localparam int RW  = BW + 2;
	localparam int PW  = BW + RW;
	localparam int unsigned RECIP = ((32'd1 << SH) + ALIGN - 1) / ALIGN;
	localparam logic [BW-1:0]  POOL_END = BW'(POOL_BYTES);
	localparam logic [BSW-1:0] ALIGN_B  = BSW'(ALIGN);

	sfla_state_t state_q, state_d;

	// Item being worked on.
	logic              op_q;
	logic [CLS_W-1:0]  cls_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BATCH_W-1:0] cstep_q;
	logic [BSW-1:0]    bsize_q;
	logic [BATCH_W-1:0] cstep_d;

	// Allocator state.
	logic [BW-1:0]          bump_q, bump_d;
	logic [SW-1:0]          bump_slot_q, bump_slot_d;
	logic [BATCH_W-1:0]     batch_q;
	logic [NUM_CLASSES-1:0] head_valid_q;
	logic [BATCH_W-1:0]     idx_q, idx_d;
	logic [LAW-1:0]         prev_slot_q, prev_slot_d;
	logic [CLS_W-1:0]       fcls_q, fcls_d;
	logic [PW-1:0]          prod_q;

	// Result registers.
	logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_load;

	// Datapath helpers.
	logic [BW-1:0]      div_in;
	logic [BW-1:0]      quo;
	logic [BW-1:0]      left;
	logic [BATCH_W-1:0] eff_batch;
	logic               carve_fits;
	logic [CAW-1:0]     cidx;
	logic [CAW-1:0]     fidx;
	logic [CLS_W-1:0]   fcls_now;

	// Memory ports and head valid update.
	logic              hw_we;
	logic [CAW-1:0]    hw_addr;
	logic [ADDR_W-1:0] hw_data;
	logic [CAW-1:0]    head_raddr;
	logic [ADDR_W-1:0] head_rdata;
	logic              hv_we;
	logic [CAW-1:0]    hv_idx;
	logic              hv_val;
	logic              lw_we;
	logic [LAW-1:0]    lw_addr;
	logic [BW-1:0]     lw_data;
	logic [BW-1:0]     link_rdata;

	sfla_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_CLASSES)) u_head_ram (
		.clk   (clk),
		.we    (hw_we),
		.waddr (hw_addr),
		.wdata (hw_data),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	sfla_ram #(.WIDTH(BW), .DEPTH(LINK_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (lw_we),
		.waddr (lw_addr),
		.wdata (lw_data),
		.raddr (quo[LAW-1:0]),
		.rdata (link_rdata)
	);

	// Shared helpers: quotient by ALIGN, space left, clamped batch.
	always_comb begin
		quo        = BW'(prod_q >> SH);
		left       = POOL_END - bump_q;
		cidx       = cls_q[CAW-1:0];
		fidx       = fcls_q[CAW-1:0];
		fcls_now   = CLS_W'(quo - BW'(1));
		cstep_d    = BATCH_W'(q_item.cls) + BATCH_W'(1);
		carve_fits = ((BW + 1)'(bump_q) + (BW + 1)'(bsize_q)) <= (BW + 1)'(POOL_BYTES);
		if (batch_q == '0) begin
			eff_batch = BATCH_W'(1);
		end else if (batch_q > BATCH_MAX) begin
			eff_batch = BATCH_MAX;
		end else begin
			eff_batch = batch_q;
		end
		head_raddr = (state_q == BK_FRAGA) ? fcls_now[CAW-1:0] : q_item.cls[CAW-1:0];
	end

	// Next state, memory writes and result.
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		div_in       = BW'(q_item.address);
		bump_d       = bump_q;
		bump_slot_d  = bump_slot_q;
		idx_d        = idx_q;
		prev_slot_d  = prev_slot_q;
		fcls_d       = fcls_q;
		res_addr_d   = res_addr_q;
		res_status_d = res_status_q;
		out_load     = 1'b0;
		hw_we        = 1'b0;
		hw_addr      = cidx;
		hw_data      = addr_q;
		hv_we        = 1'b0;
		hv_idx       = cidx;
		hv_val       = 1'b1;
		lw_we        = 1'b0;
		lw_addr      = prev_slot_q;
		lw_data      = '0;

		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop        = 1'b1;
					res_addr_d   = '0;
					res_status_d = q_item.too_big ? ST_BIG : ST_OK;
					state_d      = q_item.too_big ? BK_RES : BK_HEAD;
				end
			end
			BK_HEAD: begin
				if (op_q == OP_FREE) begin
					// Push the freed block; blocks outside the pool are ignored.
					if ((BW'(addr_q) < POOL_END) && (quo < BW'(LINK_DEPTH))) begin
						lw_we   = 1'b1;
						lw_addr = quo[LAW-1:0];
						lw_data = {head_valid_q[cidx], head_rdata};
						hw_we   = 1'b1;
						hv_we   = 1'b1;
					end
					state_d = BK_RES;
				end else if (head_valid_q[cidx]) begin
					// Pop the head; its link is read next.
					res_addr_d = head_rdata;
					div_in     = BW'(head_rdata);
					state_d    = BK_POPA;
				end else if (left >= BW'(bsize_q)) begin
					// Refill: the first carved block is the result.
					res_addr_d  = bump_q[ADDR_W-1:0];
					bump_d      = bump_q + BW'(bsize_q);
					bump_slot_d = bump_slot_q + SW'(cstep_q);
					idx_d       = BATCH_W'(1);
					state_d     = BK_CARVE;
				end else if (left >= BW'(ALIGN)) begin
					// Pool used up, but the fragment is worth keeping.
					div_in  = left;
					state_d = BK_FRAGA;
				end else begin
					bump_d       = POOL_END;
					res_status_d = ST_EXHAUSTED;
					state_d      = BK_RES;
				end
			end
			BK_POPA: begin
				state_d = BK_POPB;
			end
			BK_POPB: begin
				hw_we   = 1'b1;
				hw_data = link_rdata[ADDR_W-1:0];
				hv_we   = 1'b1;
				hv_val  = link_rdata[ADDR_W];
				state_d = BK_RES;
			end
			BK_CARVE: begin
				// One more block per cycle, linked behind the previous one.
				if ((idx_q < eff_batch) && carve_fits) begin
					if (idx_q == BATCH_W'(1)) begin
						hw_we   = 1'b1;
						hw_data = bump_q[ADDR_W-1:0];
						hv_we   = 1'b1;
					end else begin
						lw_we   = 1'b1;
						lw_data = {1'b1, bump_q[ADDR_W-1:0]};
					end
					prev_slot_d = bump_slot_q[LAW-1:0];
					bump_d      = bump_q + BW'(bsize_q);
					bump_slot_d = bump_slot_q + SW'(cstep_q);
					idx_d       = idx_q + BATCH_W'(1);
				end else begin
					if (idx_q >= BATCH_W'(2)) begin
						lw_we = 1'b1;
					end
					state_d = BK_RES;
				end
			end
			BK_FRAGA: begin
				fcls_d  = fcls_now;
				state_d = BK_FRAGB;
			end
			BK_FRAGB: begin
				if (bump_slot_q < SW'(LINK_DEPTH)) begin
					lw_we   = 1'b1;
					lw_addr = bump_slot_q[LAW-1:0];
					lw_data = {head_valid_q[fidx], head_rdata};
					hw_we   = 1'b1;
					hw_addr = fidx;
					hw_data = bump_q[ADDR_W-1:0];
					hv_we   = 1'b1;
					hv_idx  = fidx;
				end
				bump_d       = POOL_END;
				res_status_d = ST_EXHAUSTED;
				state_d      = BK_RES;
			end
			BK_RES: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			bump_q       <= '0;
			bump_slot_q  <= '0;
			batch_q      <= BATCH_RESET;
			head_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			bump_q      <= bump_d;
			bump_slot_q <= bump_slot_d;
			if (cfg_we) begin
				batch_q <= cfg_wdata;
			end
			if (hv_we) begin
				head_valid_q[hv_idx] <= hv_val;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		prod_q       <= PW'(div_in) * PW'(RECIP);
		idx_q        <= idx_d;
		prev_slot_q  <= prev_slot_d;
		fcls_q       <= fcls_d;
		res_addr_q   <= res_addr_d;
		res_status_q <= res_status_d;
		if (q_pop) begin
			op_q    <= q_item.operation;
			cls_q   <= q_item.cls;
			addr_q  <= q_item.address;
			cstep_q <= cstep_d;
			bsize_q <= BSW'(cstep_d) * ALIGN_B;
		end
		if (out_load) begin
			out_addr_q   <= (res_status_q == ST_OK) ? res_addr_q : '0;
			out_status_q <= res_status_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.address_res = out_addr_q;
	assign res.status      = out_status_q;
endmodule

`default_nettype wire

// ===== hdl/segregated_free_list_allocator.sv =====
// Segregated free-list pool allocator, top level.
// Usage:
//   Request items (req) carry an operation (allocate or free), a size in bytes and,
//   for a free, the block address. Each item gives exactly one result item (res):
//   the allocated address (zero unless ok) and a status (ok, too big, exhausted).
//   The user must write the refill batch register through cfg_we/cfg_wdata only
//   while idle; the block itself does not enforce this. Requests are classified by
//   size and placed in a two-entry queue, so the request side keeps moving while a
//   finished result waits in the output register. A refill is paced by the link
//   memory, which takes one link write per cycle.
//   Items are handled one at a time by the back-end sequencer.
//   Reset clears every list head valid bit, the bump pointer and sets the refill
//   batch to 20; the link memory needs no clearing and is ready at once.
//   When the result receiver stalls, the sequencer holds its finished result and
//   the queue fills, after which req.ready drops.
// Depends on sfla_pkg, sfla_req_if, sfla_res_if, sfla_front, sfla_queue, sfla_back.
`default_nettype none

module segregated_free_list_allocator #(
	parameter int ALIGN       = 8,
	parameter int NUM_CLASSES = 16,
	parameter int MAX_BLOCK   = 128,
	parameter int POOL_BYTES  = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sfla_req_if.sink                     req,
	sfla_res_if.source                   res,
	input  logic                         cfg_we,
	input  logic [sfla_pkg::BATCH_W-1:0] cfg_wdata
);
	import sfla_pkg::*;

	sfla_item_t front_item;
	logic       front_valid;
	logic       front_ready;
	sfla_item_t q_item;
	logic       q_valid;
	logic       q_pop;

	// Classification of incoming requests.
	sfla_front #(
		.ALIGN       (ALIGN),
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_BLOCK   (MAX_BLOCK)
	) u_front (
		.req        (req),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	// Queue between front and back end.
	sfla_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	// Allocation sequencer and result register.
	sfla_back #(
		.ALIGN       (ALIGN),
		.NUM_CLASSES (NUM_CLASSES),
		.POOL_BYTES  (POOL_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);
endmodule

`default_nettype wire

// ===== tb/sfla_alloc_checker.sv =====
// Checker for the segregated free-list allocator: watches the request, result and
// configuration ports, predicts each result and compares it with what the block returns.
// Depends on sfla_pkg, sfla_req_if and sfla_res_if.
`default_nettype none

module sfla_alloc_checker #(
	parameter int ALIGN       = 8,
	parameter int NUM_CLASSES = 16,
	parameter int MAX_BLOCK   = 128,
	parameter int POOL_BYTES  = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sfla_req_if                          req,
	sfla_res_if                          res,
	input  logic                         cfg_we,
	input  logic [sfla_pkg::BATCH_W-1:0] cfg_wdata,
	output int                           errors,
	output int                           waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import sfla_pkg::*;

	localparam int LINK_SLOTS = POOL_BYTES / ALIGN;

	typedef struct packed {
		logic [ADDR_W-1:0]   address_res;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	// Shadow copy of the allocator state: list heads carry a valid bit over the address.
	logic [ADDR_W:0]    class_head [NUM_CLASSES];
	logic [ADDR_W:0]    link_mem [LINK_SLOTS];
	int unsigned        bump;
	logic [BATCH_W-1:0] batch_reg;

	outcome_t outcomes_due[$];
	outcome_t oldest;
	outcome_t fresh;
	int       mismatches;
	int       idx;

	// Push a block onto the front of a class list.
	task automatic link_block(input int unsigned cls, input int unsigned addr);
		int unsigned slot;
		slot = addr / ALIGN;
		if (cls < NUM_CLASSES && slot < LINK_SLOTS) begin
			link_mem[slot] = class_head[cls];
			class_head[cls] = {1'b1, 16'(addr)};
		end
	endtask

	// Apply one request to the shadow state and work out the result it must give.
	task automatic serve_request(input logic op, input logic [SIZE_W-1:0] size,
		input logic [ADDR_W-1:0] addr, output outcome_t outcome);
		int unsigned cls, bsize, batch, left, n_blocks, slot, cur, i;
		outcome.address_res = '0;
		outcome.status = ST_OK;
		cls = (size == 0) ? 0 : (int'(size) + ALIGN - 1) / ALIGN - 1;
		if (int'(size) > MAX_BLOCK || cls >= NUM_CLASSES) begin
			outcome.status = ST_BIG;
		end else if (op == OP_FREE) begin
			if (int'(addr) < POOL_BYTES)
				link_block(cls, addr);
		end else if (class_head[cls][ADDR_W]) begin
			// Pop the head of the list.
			outcome.address_res = class_head[cls][ADDR_W-1:0];
			slot = class_head[cls][ADDR_W-1:0] / ALIGN;
			class_head[cls] = (slot < LINK_SLOTS) ? link_mem[slot] : '0;
		end else begin
			// Empty list: carve a batch, a partial batch, or give up on the pool.
			bsize = (cls + 1) * ALIGN;
			batch = batch_reg;
			if (batch == 0)
				batch = 1;
			if (batch > BATCH_MAX)
				batch = BATCH_MAX;
			left = (bump < POOL_BYTES) ? POOL_BYTES - bump : 0;
			if (left >= bsize * batch)
				n_blocks = batch;
			else if (left >= bsize)
				n_blocks = left / bsize;
			else
				n_blocks = 0;
			if (n_blocks == 0) begin
				if (left >= ALIGN)
					link_block(left / ALIGN - 1, bump);
				bump = POOL_BYTES;
				outcome.status = ST_EXHAUSTED;
			end else begin
				outcome.address_res = 16'(bump);
				if (n_blocks > 1) begin
					class_head[cls] = {1'b1, 16'(bump + bsize)};
					for (i = 1; i < n_blocks; i++) begin
						cur = bump + i * bsize;
						if (cur / ALIGN < LINK_SLOTS)
							link_mem[cur / ALIGN] = (i + 1 < n_blocks) ?
								{1'b1, 16'(cur + bsize)} : '0;
					end
				end
				bump = bump + n_blocks * bsize;
			end
		end
		if (outcome.status != ST_OK)
			outcome.address_res = '0;
	endtask

	// Compare results first, then predict for a request taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (idx = 0; idx < NUM_CLASSES; idx++)
				class_head[idx] = '0;
			for (idx = 0; idx < LINK_SLOTS; idx++)
				link_mem[idx] = '0;
			bump = 0;
			batch_reg = BATCH_RESET;
			outcomes_due.delete();
			mismatches = 0;
			errors = 0;
			waiting = 0;
		end else begin
			if (cfg_we)
				batch_reg = cfg_wdata;
			if (res.valid && res.ready) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual address %h status %0d",
						$time, res.address_res, res.status);
					mismatches++;
				end else begin
					oldest = outcomes_due.pop_front();
					if (res.address_res !== oldest.address_res) begin
						$display("%0t: address_res expected %h actual %h",
							$time, oldest.address_res, res.address_res);
						mismatches++;
					end
					if (res.status !== oldest.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, oldest.status, res.status);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				serve_request(req.operation, req.size_bytes, req.address, fresh);
				outcomes_due.push_back(fresh);
			end
			errors = mismatches;
			waiting = outcomes_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/segregated_free_list_allocator_tb.sv =====
// Testbench top for the segregated free-list allocator: drives requests, the result
// stall pattern and the refill batch register, and reports the verdict of the checker.
// Depends on sfla_pkg, sfla_req_if, sfla_res_if, sfla_alloc_checker and the block.
`default_nettype none

module segregated_free_list_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfla_pkg::*;

	localparam int MAX_BLOCK     = 128;
	localparam int TOTAL_ITEMS   = 950;
	localparam int RX_HOLD_TIME  = 400;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic              op;
		logic [SIZE_W-1:0] size;
	} sent_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} block_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [BATCH_W-1:0] cfg_wdata;
	int                 chk_errors;
	int                 chk_waiting;

	// Requests in flight, blocks currently held by the testbench, and phase flags.
	sent_t  in_flight[$];
	block_t held_blocks[$];
	bit     pool_gone = 1'b0;
	bit     steady = 1'b0;
	bit     rx_hold_request = 1'b0;
	int     items_sent = 0;

	sfla_req_if req_ch();
	sfla_res_if res_ch();

	segregated_free_list_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sfla_alloc_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors   (chk_errors),
		.waiting  (chk_waiting)
	);

	always #5 clk = ~clk;

	// Track what is in flight and which allocated blocks can be handed back later.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready && in_flight.size() > 0) begin
			if (in_flight[0].op == OP_ALLOC && res_ch.status == ST_OK)
				held_blocks.push_back('{res_ch.address_res, in_flight[0].size});
			if (res_ch.status == ST_EXHAUSTED)
				pool_gone = 1'b1;
			void'(in_flight.pop_front());
		end
		if (req_ch.valid && req_ch.ready)
			in_flight.push_back('{req_ch.operation, req_ch.size_bytes});
	end

	// Result side: random stalls, a quiet stretch, and one long hold-off on request.
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_request) begin
				rx_hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (RX_HOLD_TIME) @(posedge clk);
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 25);
			end
		end
	end

	// Offer one item, with an occasional gap before it, and wait until it is taken.
	task automatic send_req(input logic op, input logic [SIZE_W-1:0] size,
		input logic [ADDR_W-1:0] addr);
		if (!steady && $urandom_range(99) < 25) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.size_bytes <= size;
		req_ch.address    <= addr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
	endtask

	// Stop offering and wait until every result is back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_batch(input logic [BATCH_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		if ($urandom_range(99) < 8)
			return SIZE_W'($urandom_range(MAX_BLOCK + 1, 4095));
		return SIZE_W'($urandom_range(0, MAX_BLOCK));
	endfunction

	// Random mix: allocations, frees of held blocks, and stray frees at any address.
	// In allocation-only mode it stops as soon as the pool is used up.
	task automatic run_mix(input int count, input bit allocs_only);
		int     r;
		int     pick;
		int     n;
		block_t blk;
		for (n = 0; n < count && !(allocs_only && pool_gone); n++) begin
			r = $urandom_range(99);
			if (allocs_only || r < 50 || (r < 85 && held_blocks.size() == 0)) begin
				send_req(OP_ALLOC, pick_size(), ADDR_W'($urandom));
			end else if (r < 85) begin
				pick = $urandom_range(held_blocks.size() - 1);
				blk = held_blocks[pick];
				held_blocks.delete(pick);
				send_req(OP_FREE, blk.size, blk.addr);
			end else begin
				send_req(OP_FREE, pick_size(), ADDR_W'($urandom));
			end
		end
	endtask

	// Edge cases of size and address, with the refill batch at its reset value.
	task automatic run_directed();
		send_req(OP_ALLOC, 12'd0, 16'hFFFF);
		send_req(OP_ALLOC, 12'd1, 16'h0000);
		send_req(OP_ALLOC, 12'd8, 16'h0000);
		send_req(OP_ALLOC, 12'd9, 16'h0000);
		send_req(OP_ALLOC, 12'd128, 16'h0000);
		send_req(OP_ALLOC, 12'd129, 16'h0000);
		send_req(OP_ALLOC, 12'd4095, 16'hFFFF);
		send_req(OP_FREE, 12'd4095, 16'hFFFF);
		// A misaligned free goes back out exactly as given.
		send_req(OP_FREE, 12'd0, 16'h0003);
		send_req(OP_ALLOC, 12'd0, 16'h0000);
		send_req(OP_FREE, 12'd128, 16'hFFFF);
		send_req(OP_ALLOC, 12'd128, 16'h0000);
		send_req(OP_ALLOC, 12'd120, 16'h0000);
		send_req(OP_FREE, 12'd128, 16'h0000);
		send_req(OP_ALLOC, 12'd64, 16'h0000);
		send_req(OP_FREE, 12'd16, 16'hAAAA);
		send_req(OP_FREE, 12'd16, 16'h5555);
		send_req(OP_ALLOC, 12'd16, 16'h0000);
		send_req(OP_ALLOC, 12'd16, 16'h0000);
		send_req(OP_ALLOC, 12'd128, 16'h0000);
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.operation  <= OP_ALLOC;
		req_ch.size_bytes <= '0;
		req_ch.address    <= '0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		// A batch of zero refills one block at a time.
		set_batch(7'd0);
		run_mix(150, 1'b0);
		drain();

		// Mid-range batch with neither side idling.
		set_batch(BATCH_W'($urandom_range(2, 63)));
		steady = 1'b1;
		run_mix(150, 1'b0);
		steady = 1'b0;
		drain();

		// Oversized batch while the result side holds off, so the input backs up.
		set_batch(7'd127);
		rx_hold_request = 1'b1;
		run_mix(150, 1'b0);
		drain();

		// Full batches and allocations only, until the pool runs dry.
		set_batch(BATCH_MAX);
		run_mix(250, 1'b1);
		drain();

		set_batch(7'd1);
		run_mix((TOTAL_ITEMS > items_sent + 100) ? TOTAL_ITEMS - items_sent : 100, 1'b0);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (chk_waiting != 0)
			$display("%0t: %0d expected results never arrived", $time, chk_waiting);
		if (chk_errors == 0 && chk_waiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
